// ===== rtl/stol_pkg.sv =====
// ----------------------------------------------------------------------------
// stol_pkg
// codes and shared types of the sample table offset lookup
// ----------------------------------------------------------------------------
package stol_pkg;

  localparam logic [1:0] FUNC_RUN   = 2'd0;
  localparam logic [1:0] FUNC_CHUNK = 2'd1;
  localparam logic [1:0] FUNC_SIZE  = 2'd2;
  localparam logic [1:0] FUNC_QUERY = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_RUNS   = 2'd1;
  localparam logic [1:0] ST_BAD_CHUNK = 2'd2;
  localparam logic [1:0] ST_BAD_SIZE  = 2'd3;

  localparam logic [1:0] CFG_FIXED  = 2'd0;
  localparam logic [1:0] CFG_RUNS   = 2'd1;
  localparam logic [1:0] CFG_CHUNKS = 2'd2;
  localparam logic [1:0] CFG_SIZES  = 2'd3;

  typedef struct packed {
    logic [31:0] fixed_sample_size;
    logic [8:0]  run_count;
    logic [12:0] chunk_count;
    logic [14:0] size_count;
  } cfg_regs_t;

  typedef struct packed {
    logic [63:0] sample_offset;
    logic [31:0] sample_bytes;
    logic [1:0]  status;
  } result_t;

endpackage

// ===== rtl/stol_if.sv =====
// ----------------------------------------------------------------------------
// stol_if
// request, response and configuration channels
// ----------------------------------------------------------------------------
interface stol_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [13:0] entry_index;
  logic [31:0] start_chunk;
  logic [31:0] chunk_samples;
  logic [63:0] chunk_offset;
  logic [31:0] entry_sample_size;
  logic [31:0] sample_number;
  modport source(output valid, func, entry_index, start_chunk, chunk_samples,
                 chunk_offset, entry_sample_size, sample_number, input ready);
  modport sink(input valid, func, entry_index, start_chunk, chunk_samples,
               chunk_offset, entry_sample_size, sample_number, output ready);
endinterface

interface stol_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] sample_offset;
  logic [31:0] sample_bytes;
  logic [1:0]  status;
  modport source(output valid, sample_offset, sample_bytes, status, input ready);
  modport sink(input valid, sample_offset, sample_bytes, status, output ready);
endinterface

interface stol_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/stol_ram.sv =====
// ----------------------------------------------------------------------------
// stol_ram
// simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module stol_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/stol_queue.sv =====
// ----------------------------------------------------------------------------
// stol_queue
// short fifo of pending query sample numbers
// ----------------------------------------------------------------------------
module stol_queue #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty,
  output logic             full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign empty    = (count == '0);
  assign full     = (count == CW'(DEPTH));
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        mem[wr_ptr] <= push_data;
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ===== rtl/stol_front.sv =====
// ----------------------------------------------------------------------------
// stol_front
// accepts request transactions, writes loads into the tables, queues queries
// ----------------------------------------------------------------------------
module stol_front #(
  parameter int RUN_DEPTH   = 256,
  parameter int CHUNK_DEPTH = 4096,
  parameter int SIZE_DEPTH  = 16384,
  parameter int RAW = (RUN_DEPTH > 1) ? $clog2(RUN_DEPTH) : 1,
  parameter int CAW = (CHUNK_DEPTH > 1) ? $clog2(CHUNK_DEPTH) : 1,
  parameter int SAW = (SIZE_DEPTH > 1) ? $clog2(SIZE_DEPTH) : 1
) (
  stol_in_if.sink      req,
  input  logic         q_empty,
  input  logic         q_full,
  input  logic         back_busy,
  output logic         push,
  output logic [31:0]  push_data,
  output logic         run_we,
  output logic [RAW-1:0] run_waddr,
  output logic [63:0]  run_wdata,
  output logic         chunk_we,
  output logic [CAW-1:0] chunk_waddr,
  output logic [63:0]  chunk_wdata,
  output logic         size_we,
  output logic [SAW-1:0] size_waddr,
  output logic [31:0]  size_wdata
);
  import stol_pkg::*;

  logic        acc;
  logic        quiet;
  logic [31:0] idx32;

  // loads wait until no query is pending, so queries see the tables in order
  assign quiet     = q_empty && !back_busy;
  assign req.ready = (req.func == FUNC_QUERY) ? !q_full : quiet;
  assign acc       = req.valid && req.ready;
  assign idx32     = 32'(req.entry_index);

  assign push      = acc && (req.func == FUNC_QUERY);
  assign push_data = req.sample_number;

  assign run_we    = acc && (req.func == FUNC_RUN) && (idx32 < 32'(RUN_DEPTH));
  assign run_waddr = idx32[RAW-1:0];
  assign run_wdata = {req.start_chunk, req.chunk_samples};

  assign chunk_we    = acc && (req.func == FUNC_CHUNK) && (idx32 < 32'(CHUNK_DEPTH));
  assign chunk_waddr = idx32[CAW-1:0];
  assign chunk_wdata = req.chunk_offset;

  assign size_we    = acc && (req.func == FUNC_SIZE) && (idx32 < 32'(SIZE_DEPTH));
  assign size_waddr = idx32[SAW-1:0];
  assign size_wdata = req.entry_sample_size;

endmodule

// ===== rtl/stol_back.sv =====
// ----------------------------------------------------------------------------
// stol_back
// query engine: run walk, chunk divide, offset sum, result register
// ----------------------------------------------------------------------------
module stol_back #(
  parameter int RUN_DEPTH   = 256,
  parameter int CHUNK_DEPTH = 4096,
  parameter int SIZE_DEPTH  = 16384,
  parameter int RAW = (RUN_DEPTH > 1) ? $clog2(RUN_DEPTH) : 1,
  parameter int CAW = (CHUNK_DEPTH > 1) ? $clog2(CHUNK_DEPTH) : 1,
  parameter int SAW = (SIZE_DEPTH > 1) ? $clog2(SIZE_DEPTH) : 1
) (
  input  logic                clk,
  input  logic                rst,
  input  stol_pkg::cfg_regs_t cfg,
  input  logic                q_empty,
  input  logic [31:0]         q_data,
  output logic                pop,
  output logic [RAW-1:0]      run_raddr,
  input  logic [63:0]         run_rdata,
  output logic [CAW-1:0]      chunk_raddr,
  input  logic [63:0]         chunk_rdata,
  output logic [SAW-1:0]      size_raddr,
  input  logic [31:0]         size_rdata,
  output logic                busy,
  stol_out_if.source          rsp
);
  import stol_pkg::*;

  localparam int RCW = $clog2(RUN_DEPTH + 1);
  localparam int CCW = $clog2(CHUNK_DEPTH + 1);
  localparam int SCW = $clog2(SIZE_DEPTH + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RRD   = 4'd1;
  localparam logic [3:0] S_RLOAD = 4'd2;
  localparam logic [3:0] S_RTEST = 4'd3;
  localparam logic [3:0] S_RMUL  = 4'd4;
  localparam logic [3:0] S_RCMP  = 4'd5;
  localparam logic [3:0] S_DINIT = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_CHK   = 4'd8;
  localparam logic [3:0] S_CRD   = 4'd9;
  localparam logic [3:0] S_COFF  = 4'd10;
  localparam logic [3:0] S_FADD  = 4'd11;
  localparam logic [3:0] S_SRD   = 4'd12;
  localparam logic [3:0] S_SACC  = 4'd13;
  localparam logic [3:0] S_DONE  = 4'd14;

  logic [3:0]     state;
  logic [31:0]    sample;
  logic [31:0]    skipped;
  logic [RAW-1:0] r;
  logic [31:0]    a;
  logic [31:0]    spc;
  logic [31:0]    b;
  logic [31:0]    nspc;
  logic [63:0]    in_run;
  logic [31:0]    rem;
  logic [31:0]    quo;
  logic [4:0]     cnt;
  logic [CAW-1:0] cidx;
  logic [63:0]    offs;
  logic [63:0]    prod;
  logic [SAW-1:0] j;
  result_t        res;
  result_t        out;
  logic           out_valid;

  logic [RCW-1:0] runs;
  logic [CCW-1:0] chunks;
  logic [SCW-1:0] sizes;
  logic [31:0]    span;
  logic [32:0]    dtrial;
  logic [32:0]    chunk_no;
  logic [31:0]    in_chunk;

  assign runs   = (32'(cfg.run_count) > 32'(RUN_DEPTH)) ? RCW'(RUN_DEPTH)
                                                        : RCW'(cfg.run_count);
  assign chunks = (32'(cfg.chunk_count) > 32'(CHUNK_DEPTH)) ? CCW'(CHUNK_DEPTH)
                                                            : CCW'(cfg.chunk_count);
  assign sizes  = (32'(cfg.size_count) > 32'(SIZE_DEPTH)) ? SCW'(SIZE_DEPTH)
                                                          : SCW'(cfg.size_count);

  assign span     = (run_rdata[63:32] > a) ? run_rdata[63:32] - a : 32'd0;
  assign dtrial   = {rem, quo[31]};
  assign chunk_no = {1'b0, a} + {1'b0, quo};
  assign in_chunk = rem;

  assign busy        = (state != S_IDLE);
  assign pop         = (state == S_IDLE) && !q_empty;
  assign chunk_raddr = cidx;
  assign size_raddr  = j;

  always_comb begin
    if (state == S_RTEST) begin
      run_raddr = RAW'(32'(r) + 32'd1);
    end else begin
      run_raddr = r;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.sample_offset = out.sample_offset;
  assign rsp.sample_bytes  = out.sample_bytes;
  assign rsp.status        = out.status;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // result register: load from the done step, or drain on accept
      if (state == S_DONE && (!out_valid || rsp.ready)) begin
        out       <= res;
        out_valid <= 1'b1;
      end else if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            sample  <= q_data;
            skipped <= '0;
            r       <= '0;
            if (runs == '0) begin
              res   <= '{64'd0, 32'd0, ST_NO_RUNS};
              state <= S_DONE;
            end else begin
              state <= S_RRD;
            end
          end
        end
        S_RRD: begin
          state <= S_RLOAD;
        end
        S_RLOAD: begin
          a     <= run_rdata[63:32];
          spc   <= run_rdata[31:0];
          state <= S_RTEST;
        end
        S_RTEST: begin
          if (32'(r) + 32'd1 < 32'(runs)) begin
            state <= S_RMUL;
          end else begin
            state <= S_DINIT;
          end
        end
        S_RMUL: begin
          in_run <= span * spc;
          b      <= run_rdata[63:32];
          nspc   <= run_rdata[31:0];
          state  <= S_RCMP;
        end
        S_RCMP: begin
          if ({33'd0, sample} < {33'd0, skipped} + {1'b0, in_run}) begin
            state <= S_DINIT;
          end else begin
            skipped <= skipped + in_run[31:0];
            a       <= b;
            spc     <= nspc;
            r       <= r + RAW'(1);
            state   <= S_RTEST;
          end
        end
        S_DINIT: begin
          if (spc == '0) begin
            res   <= '{64'd0, 32'd0, ST_BAD_CHUNK};
            state <= S_DONE;
          end else begin
            rem   <= '0;
            quo   <= sample - skipped;
            cnt   <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          // restoring divide, one quotient bit per cycle
          if (dtrial >= {1'b0, spc}) begin
            rem <= 32'(dtrial - {1'b0, spc});
            quo <= {quo[30:0], 1'b1};
          end else begin
            rem <= dtrial[31:0];
            quo <= {quo[30:0], 1'b0};
          end
          cnt <= cnt + 5'd1;
          if (cnt == 5'd31) begin
            state <= S_CHK;
          end
        end
        S_CHK: begin
          if (chunk_no == '0 || chunk_no - 33'd1 >= 33'(chunks)) begin
            res   <= '{64'd0, 32'd0, ST_BAD_CHUNK};
            state <= S_DONE;
          end else begin
            cidx  <= CAW'(chunk_no - 33'd1);
            state <= S_CRD;
          end
        end
        S_CRD: begin
          state <= S_COFF;
        end
        S_COFF: begin
          offs <= chunk_rdata;
          if (cfg.fixed_sample_size != '0) begin
            prod  <= cfg.fixed_sample_size * in_chunk;
            state <= S_FADD;
          end else if (sample >= 32'(sizes)) begin
            res   <= '{64'd0, 32'd0, ST_BAD_SIZE};
            state <= S_DONE;
          end else begin
            j     <= SAW'(sample - in_chunk);
            state <= S_SRD;
          end
        end
        S_FADD: begin
          res   <= '{offs + prod, cfg.fixed_sample_size, ST_OK};
          state <= S_DONE;
        end
        S_SRD: begin
          state <= S_SACC;
        end
        S_SACC: begin
          if (j == SAW'(sample)) begin
            res   <= '{offs, size_rdata, ST_OK};
            state <= S_DONE;
          end else begin
            offs  <= offs + 64'(size_rdata);
            j     <= j + SAW'(1);
            state <= S_SRD;
          end
        end
        S_DONE: begin
          if (!out_valid || rsp.ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> spc != '0)
    else $error("divide started with zero samples per chunk");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE)
    else $error("result raised outside the done step");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out.status != ST_OK |-> out.sample_offset == '0 && out.sample_bytes == '0)
    else $error("error result carries nonzero payload");

endmodule

// ===== rtl/sample_table_offset_lookup.sv =====
// ----------------------------------------------------------------------------
// sample_table_offset_lookup
// sample-to-chunk, chunk offset and sample size tables with offset queries
// ----------------------------------------------------------------------------
//  channel  dir  moves
//  req      in   load run / chunk offset / sample size, or query
//  rsp      out  sample_offset, sample_bytes, status (one per query)
//  cfg      in   register write: index, data
//
//  a load waits while any query is queued or in work
//  a query fetches run 0, walks the run boundaries, divides, checks and reads
//  the chunk, then adds a fixed size product or walks the size table
//  the divider is bit-serial and the size ram has a single read port
//  rsp is a registered output; up to two queries wait in the queue
//  reset is synchronous; tables hold no reset value and need no clear pass
// ----------------------------------------------------------------------------
module sample_table_offset_lookup #(
  parameter int RUN_DEPTH   = 256,
  parameter int CHUNK_DEPTH = 4096,
  parameter int SIZE_DEPTH  = 16384
) (
  input  logic       clk,
  input  logic       rst,
  stol_in_if.sink    req,
  stol_out_if.source rsp,
  stol_cfg_if.sink   cfg
);
  import stol_pkg::*;

  localparam int RAW = (RUN_DEPTH > 1) ? $clog2(RUN_DEPTH) : 1;
  localparam int CAW = (CHUNK_DEPTH > 1) ? $clog2(CHUNK_DEPTH) : 1;
  localparam int SAW = (SIZE_DEPTH > 1) ? $clog2(SIZE_DEPTH) : 1;

  // configuration registers
  cfg_regs_t regs;

  // queue between front and back
  logic        push;
  logic [31:0] push_data;
  logic        pop;
  logic [31:0] pop_data;
  logic        q_empty;
  logic        q_full;
  logic        back_busy;

  // table ports
  logic           run_we;
  logic [RAW-1:0] run_waddr;
  logic [63:0]    run_wdata;
  logic [RAW-1:0] run_raddr;
  logic [63:0]    run_rdata;
  logic           chunk_we;
  logic [CAW-1:0] chunk_waddr;
  logic [63:0]    chunk_wdata;
  logic [CAW-1:0] chunk_raddr;
  logic [63:0]    chunk_rdata;
  logic           size_we;
  logic [SAW-1:0] size_waddr;
  logic [31:0]    size_wdata;
  logic [SAW-1:0] size_raddr;
  logic [31:0]    size_rdata;

  // every cfg transaction is taken at once
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_FIXED:  regs.fixed_sample_size <= cfg.data;
        CFG_RUNS:   regs.run_count         <= cfg.data[8:0];
        CFG_CHUNKS: regs.chunk_count       <= cfg.data[12:0];
        CFG_SIZES:  regs.size_count        <= cfg.data[14:0];
        default: begin
        end
      endcase
    end
  end

  // front: classify and write loads, queue queries
  stol_front #(
    .RUN_DEPTH(RUN_DEPTH), .CHUNK_DEPTH(CHUNK_DEPTH), .SIZE_DEPTH(SIZE_DEPTH)
  ) u_front (
    .req(req), .q_empty(q_empty), .q_full(q_full), .back_busy(back_busy),
    .push(push), .push_data(push_data),
    .run_we(run_we), .run_waddr(run_waddr), .run_wdata(run_wdata),
    .chunk_we(chunk_we), .chunk_waddr(chunk_waddr), .chunk_wdata(chunk_wdata),
    .size_we(size_we), .size_waddr(size_waddr), .size_wdata(size_wdata)
  );

  stol_queue #(.WIDTH(32), .DEPTH(2)) u_queue (
    .clk(clk), .rst(rst), .push(push), .push_data(push_data),
    .pop(pop), .pop_data(pop_data), .empty(q_empty), .full(q_full)
  );

  // run table keeps first chunk in the upper word, samples per chunk below
  stol_ram #(.WIDTH(64), .DEPTH(RUN_DEPTH)) u_run_ram (
    .clk(clk), .we(run_we), .waddr(run_waddr), .wdata(run_wdata),
    .raddr(run_raddr), .rdata(run_rdata)
  );

  stol_ram #(.WIDTH(64), .DEPTH(CHUNK_DEPTH)) u_chunk_ram (
    .clk(clk), .we(chunk_we), .waddr(chunk_waddr), .wdata(chunk_wdata),
    .raddr(chunk_raddr), .rdata(chunk_rdata)
  );

  stol_ram #(.WIDTH(32), .DEPTH(SIZE_DEPTH)) u_size_ram (
    .clk(clk), .we(size_we), .waddr(size_waddr), .wdata(size_wdata),
    .raddr(size_raddr), .rdata(size_rdata)
  );

  // back: the query engine and result register
  stol_back #(
    .RUN_DEPTH(RUN_DEPTH), .CHUNK_DEPTH(CHUNK_DEPTH), .SIZE_DEPTH(SIZE_DEPTH)
  ) u_back (
    .clk(clk), .rst(rst), .cfg(regs),
    .q_empty(q_empty), .q_data(pop_data), .pop(pop),
    .run_raddr(run_raddr), .run_rdata(run_rdata),
    .chunk_raddr(chunk_raddr), .chunk_rdata(chunk_rdata),
    .size_raddr(size_raddr), .size_rdata(size_rdata),
    .busy(back_busy), .rsp(rsp)
  );

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the sample table offset lookup: a directed table of
// loads, register writes and queries, then random phases of register writes, loads
// and queries, each answer checked field by field against a scripted answer or a local lookup
// ----------------------------------------------------------------------------
module tb_top;
  import stol_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RUNS_MAX   = 256;
  localparam int CHUNKS_MAX = 4096;
  localparam int SIZES_MAX  = 16384;
  localparam int ITEM_GOAL  = 1700;
  localparam int CALM_AFTER = 1500;
  localparam int SETTLE     = 16;
  localparam longint CYCLE_LIMIT = 10_000_000;

  // one request transaction
  typedef struct packed {
    logic [1:0]  func;
    logic [13:0] idx;
    logic [31:0] first;
    logic [31:0] spc;
    logic [63:0] offs;
    logic [31:0] bytes;
    logic [31:0] samp;
  } req_item_t;

  // one row of the directed table: a register write or a request
  typedef struct {
    bit          is_reg;
    logic [1:0]  reg_idx;
    logic [31:0] reg_data;
    req_item_t   item;
    bit          typed;
    result_t     want;
  } script_row_t;

  logic clk = 1'b0;
  logic rst;

  stol_in_if  req();
  stol_out_if rsp();
  stol_cfg_if cfg();

  sample_table_offset_lookup dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cfg (cfg)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // local copy of the tables, with a written flag per entry
  logic [31:0] run_first [RUNS_MAX];
  logic [31:0] run_spc   [RUNS_MAX];
  logic [63:0] chunk_tab [CHUNKS_MAX];
  logic [31:0] size_tab  [SIZES_MAX];
  bit          run_seen   [RUNS_MAX];
  bit          chunk_seen [CHUNKS_MAX];
  bit          size_seen  [SIZES_MAX];
  cfg_regs_t   regs;

  result_t     awaited_answers[$];
  script_row_t script[$];
  int          mismatches = 0;
  int          sent = 0;
  bit          calm = 1'b0;
  longint      cycles = 0;
  int          rsp_stall = 0;

  // offset lookup of one sample; blind marks a read of a never-written entry
  function automatic void locate_sample(input logic [31:0] samp, output result_t res,
                                        output bit blind);
    int unsigned runs, chunks, sizes, r;
    logic [63:0] skipped, span, in_run, spc, rel, chunk_no, in_chunk, offs, j;
    blind   = 1'b0;
    res     = '0;
    skipped = '0;
    r       = 0;
    runs   = (regs.run_count > RUNS_MAX) ? RUNS_MAX : regs.run_count;
    chunks = (regs.chunk_count > CHUNKS_MAX) ? CHUNKS_MAX : regs.chunk_count;
    sizes  = (regs.size_count > SIZES_MAX) ? SIZES_MAX : regs.size_count;
    if (runs == 0) begin
      res.status = ST_NO_RUNS;
      return;
    end
    // walk runs; a run with a non-increasing successor covers nothing
    while (r + 1 < runs) begin
      if (!run_seen[r] || !run_seen[r+1]) blind = 1'b1;
      span   = (run_first[r+1] > run_first[r]) ? 64'(run_first[r+1] - run_first[r]) : 64'd0;
      in_run = span * 64'(run_spc[r]);
      if (64'(samp) < skipped + in_run) break;
      skipped += in_run;
      r++;
    end
    if (!run_seen[r]) blind = 1'b1;
    spc = 64'(run_spc[r]);
    if (spc == 0) begin
      res.status = ST_BAD_CHUNK;
      return;
    end
    rel      = 64'(samp) - skipped;
    chunk_no = 64'(run_first[r]) + rel / spc;
    in_chunk = rel % spc;
    if (chunk_no == 0 || chunk_no - 1 >= 64'(chunks)) begin
      res.status = ST_BAD_CHUNK;
      return;
    end
    if (!chunk_seen[chunk_no-1]) blind = 1'b1;
    offs = chunk_tab[chunk_no-1];
    if (regs.fixed_sample_size != 0) begin
      res.sample_offset = offs + 64'(regs.fixed_sample_size) * in_chunk;
      res.sample_bytes  = regs.fixed_sample_size;
      res.status        = ST_OK;
      return;
    end
    if (64'(samp) >= 64'(sizes)) begin
      res.status = ST_BAD_SIZE;
      return;
    end
    // sum the sizes of the earlier samples of the same chunk
    for (j = 64'(samp) - in_chunk; j < 64'(samp); j++) begin
      if (!size_seen[j]) blind = 1'b1;
      offs += 64'(size_tab[j]);
    end
    if (!size_seen[samp]) blind = 1'b1;
    res.sample_offset = offs;
    res.sample_bytes  = size_tab[samp];
    res.status        = ST_OK;
  endfunction

  function automatic req_item_t make_item(logic [1:0] func, logic [13:0] idx,
                                          logic [31:0] first, logic [31:0] spc,
                                          logic [63:0] offs, logic [31:0] bytes,
                                          logic [31:0] samp);
    req_item_t it;
    it.func  = func;
    it.idx   = idx;
    it.first = first;
    it.spc   = spc;
    it.offs  = offs;
    it.bytes = bytes;
    it.samp  = samp;
    return it;
  endfunction

  function automatic void add_row(req_item_t it, bit typed = 1'b0, result_t want = '0);
    script_row_t row;
    row.is_reg   = 1'b0;
    row.reg_idx  = CFG_FIXED;
    row.reg_data = '0;
    row.item     = it;
    row.typed    = typed;
    row.want     = want;
    script.push_back(row);
  endfunction

  function automatic void add_reg_row(logic [1:0] idx, logic [31:0] data);
    script_row_t row;
    row = '{default: '0};
    row.is_reg   = 1'b1;
    row.reg_idx  = idx;
    row.reg_data = data;
    script.push_back(row);
  endfunction

  function automatic result_t answer(logic [63:0] offs, logic [31:0] bytes, logic [1:0] st);
    result_t res;
    res.sample_offset = offs;
    res.sample_bytes  = bytes;
    res.status        = st;
    return res;
  endfunction

  // a load updates the local tables; slots past the depth are dropped
  function automatic void store_load(req_item_t it);
    case (it.func)
      FUNC_RUN: begin
        if (it.idx < RUNS_MAX) begin
          run_first[it.idx] = it.first;
          run_spc[it.idx]   = it.spc;
          run_seen[it.idx]  = 1'b1;
        end
      end
      FUNC_CHUNK: begin
        if (it.idx < CHUNKS_MAX) begin
          chunk_tab[it.idx]  = it.offs;
          chunk_seen[it.idx] = 1'b1;
        end
      end
      FUNC_SIZE: begin
        if (it.idx < SIZES_MAX) begin
          size_tab[it.idx]  = it.bytes;
          size_seen[it.idx] = 1'b1;
        end
      end
      default: ;
    endcase
  endfunction

  task automatic hold_off(int n);
    req.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // drives one request; valid stays high afterwards so back-to-back items
  // need no second assignment in the same step
  task automatic send_item(req_item_t it, bit typed = 1'b0, result_t want = '0);
    bit      taken;
    bit      blind;
    result_t res;
    req.valid             <= 1'b1;
    req.func              <= it.func;
    req.entry_index       <= it.idx;
    req.start_chunk       <= it.first;
    req.chunk_samples     <= it.spc;
    req.chunk_offset      <= it.offs;
    req.entry_sample_size <= it.bytes;
    req.sample_number     <= it.samp;
    do begin
      @(negedge clk);
      taken = req.ready;
      @(posedge clk);
    end while (!taken);
    sent++;
    if (it.func == FUNC_QUERY) begin
      locate_sample(it.samp, res, blind);
      awaited_answers.push_back(typed ? want : res);
    end else begin
      store_load(it);
    end
  endtask

  // register writes only once every answer is back and loads have settled
  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    bit taken;
    req.valid <= 1'b0;
    while (awaited_answers.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= data;
    do begin
      @(negedge clk);
      taken = cfg.ready;
      @(posedge clk);
    end while (!taken);
    cfg.valid <= 1'b0;
    case (idx)
      CFG_FIXED:  regs.fixed_sample_size = data;
      CFG_RUNS:   regs.run_count         = data[8:0];
      CFG_CHUNKS: regs.chunk_count       = data[12:0];
      CFG_SIZES:  regs.size_count        = data[14:0];
      default: ;
    endcase
    repeat (2) @(posedge clk);
  endtask

  task automatic maybe_gap();
    if (!calm && $urandom_range(0, 5) == 0) hold_off($urandom_range(1, 15));
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // one random phase: registers, table fill, then mixed loads and queries
  task automatic random_phase(int phase_no, int n_ops);
    int unsigned nr, cc, sc, nchunk, nsize, reach;
    logic [31:0] fc, fixed;
    req_item_t   it;
    result_t     res;
    bit          blind, found;
    // table sizes: mostly small, a few at or past the extremes
    case (phase_no)
      0:       nr = RUNS_MAX;
      1:       nr = 511;
      default: nr = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
    endcase
    case ($urandom_range(0, 5))
      0:       cc = CHUNKS_MAX;
      1:       cc = 8191;
      default: cc = $urandom_range(1, 80);
    endcase
    case ($urandom_range(0, 5))
      0:       sc = SIZES_MAX;
      1:       sc = 32767;
      2:       sc = 0;
      default: sc = $urandom_range(1, 300);
    endcase
    case ($urandom_range(0, 5))
      0:       fixed = 32'hFFFF_FFFF;
      1:       fixed = 32'd1;
      2:       fixed = $urandom;
      default: fixed = 32'd0;
    endcase
    write_reg(CFG_FIXED, fixed);
    write_reg(CFG_RUNS, nr);
    write_reg(CFG_CHUNKS, cc);
    write_reg(CFG_SIZES, sc);

    // runs: mostly well-formed increasing first chunks, some broken entries
    fc = 32'd1;
    for (int i = 0; i < ((nr > RUNS_MAX) ? RUNS_MAX : nr); i++) begin
      it = make_item(FUNC_RUN, 14'(i), fc, $urandom_range(1, 6), rand64(), $urandom, $urandom);
      if ($urandom_range(0, 12) == 0) begin
        it.first = $urandom;
        it.spc   = ($urandom_range(0, 1) == 0) ? 32'd0 : $urandom;
      end else begin
        fc += $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 4);
      end
      maybe_gap();
      send_item(it);
    end
    nchunk = (cc < fc + 2) ? cc : fc + 2;
    if (nchunk > 200) nchunk = 200;
    for (int i = 0; i < nchunk; i++) begin
      maybe_gap();
      send_item(make_item(FUNC_CHUNK, 14'(i), $urandom, $urandom, rand64(), $urandom,
                          $urandom));
    end
    reach = fc * 6;
    nsize = (sc < reach) ? sc : reach;
    if (nsize > 300) nsize = 300;
    if (fixed == 0) begin
      for (int i = 0; i < nsize; i++) begin
        maybe_gap();
        send_item(make_item(FUNC_SIZE, 14'(i), $urandom, $urandom,
                            rand64(), $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 5000),
                            $urandom));
      end
    end

    for (int k = 0; k < n_ops; k++) begin
      found = 1'b0;
      if ($urandom_range(0, 4) != 0) begin
        // queries that would read an unfilled entry are redrawn
        for (int t = 0; t < 8 && !found; t++) begin
          it = make_item(FUNC_QUERY, 14'($urandom), $urandom, $urandom, rand64(), $urandom, 0);
          case ($urandom_range(0, 9))
            0:       it.samp = $urandom;
            1:       it.samp = ($urandom_range(0, 1) == 0) ? 32'd0 : 32'hFFFF_FFFF;
            default: it.samp = $urandom_range(0, reach);
          endcase
          locate_sample(it.samp, res, blind);
          found = !blind;
        end
      end
      if (!found) begin
        // overwrite a filled slot, or poke a random slot far out
        it = make_item(2'($urandom_range(0, 2)), 0, $urandom, $urandom, rand64(), $urandom,
                       $urandom);
        it.idx = ($urandom_range(0, 3) == 0) ? 14'($urandom_range(0, 16383)) :
                 14'($urandom_range(0, nchunk + 1));
        if (it.func == FUNC_RUN && it.idx < RUNS_MAX && run_seen[it.idx] &&
            $urandom_range(0, 1) == 0) begin
          it.first = run_first[it.idx];
          it.spc   = $urandom_range(1, 6);
        end
      end
      maybe_gap();
      send_item(it);
      if (sent > CALM_AFTER) calm = 1'b1;
      // now and then stop feeding until every answer is back
      if (!calm && awaited_answers.size() != 0 && $urandom_range(0, 60) == 0) begin
        req.valid <= 1'b0;
        while (awaited_answers.size() != 0) @(posedge clk);
      end
    end
  endtask

  // response ready: random stall bursts, none near the end
  always @(posedge clk) begin
    if (rsp_stall > 0) begin
      rsp_stall <= rsp_stall - 1;
      rsp.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      rsp_stall <= $urandom_range(0, 14);
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  // answer check: values are stable at the falling edge before the accepting edge
  always @(negedge clk) begin
    result_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (awaited_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected answer: offset %h bytes %h status %0d",
                   rsp.sample_offset, rsp.sample_bytes, rsp.status);
      end else begin
        want = awaited_answers.pop_front();
        if (rsp.sample_offset !== want.sample_offset || rsp.sample_bytes !== want.sample_bytes ||
            rsp.status !== want.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("answer mismatch: offset %h/%h bytes %h/%h status %0d/%0d (exp/act)",
                     want.sample_offset, rsp.sample_offset, want.sample_bytes,
                     rsp.sample_bytes, want.status, rsp.status);
        end
      end
    end
  end

  // run time limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    rst                   = 1'b1;
    req.valid             = 1'b0;
    req.func              = FUNC_RUN;
    req.entry_index       = '0;
    req.start_chunk       = '0;
    req.chunk_samples     = '0;
    req.chunk_offset      = '0;
    req.entry_sample_size = '0;
    req.sample_number     = '0;
    cfg.valid             = 1'b0;
    cfg.index             = CFG_FIXED;
    cfg.data              = '0;
    rsp.ready             = 1'b0;
    regs                  = '0;
    foreach (run_seen[i]) run_seen[i] = 1'b0;
    foreach (chunk_seen[i]) chunk_seen[i] = 1'b0;
    foreach (size_seen[i]) size_seen[i] = 1'b0;

    // directed table: empty run table, field extremes, every error status
    add_row(make_item(FUNC_QUERY, 0, 0, 0, 0, 0, 32'd0), 1, answer(0, 0, ST_NO_RUNS));
    add_row(make_item(FUNC_QUERY, 0, 0, 0, 0, 0, 32'hFFFF_FFFF), 1, answer(0, 0, ST_NO_RUNS));
    add_row(make_item(FUNC_RUN, 0, 32'd1, 32'd2, 0, 0, 0));
    add_row(make_item(FUNC_RUN, 14'h3FFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1, '1, '1));
    add_row(make_item(FUNC_CHUNK, 0, 0, 0, 64'hFFFF_FFFF_FFFF_FFF0, 0, 0));
    add_row(make_item(FUNC_CHUNK, 1, 0, 0, 64'd100, 0, 0));
    add_row(make_item(FUNC_SIZE, 0, 0, 0, 0, 32'd5, 0));
    add_row(make_item(FUNC_SIZE, 1, 0, 0, 0, 32'd7, 0));
    add_row(make_item(FUNC_SIZE, 2, 0, 0, 0, 32'hFFFF_FFFF, 0));
    add_row(make_item(FUNC_SIZE, 3, 0, 0, 0, 32'd9, 0));
    add_reg_row(CFG_RUNS, 32'd1);
    add_reg_row(CFG_CHUNKS, 32'd2);
    add_reg_row(CFG_SIZES, 32'd4);
    add_row(make_item(FUNC_QUERY, 0, 0, 0, 0, 0, 32'd0), 1,
            answer(64'hFFFF_FFFF_FFFF_FFF0, 32'd5, ST_OK));
    add_row(make_item(FUNC_QUERY, 0, 0, 0, 0, 0, 32'd1), 1,
            answer(64'hFFFF_FFFF_FFFF_FFF5, 32'd7, ST_OK));
    add_row(make_item(FUNC_QUERY, 0, 0, 0, 0, 0, 32'd3));
    add_row(make_item(FUNC_QUERY, 0, 0, 0, 0, 0, 32'd4), 1, answer(0, 0, ST_BAD_CHUNK));
    add_row(make_item(FUNC_QUERY, 0, 0, 0, 0, 0, 32'hFFFF_FFFF), 1,
            answer(0, 0, ST_BAD_CHUNK));
    add_reg_row(CFG_SIZES, 32'd3);
    add_row(make_item(FUNC_QUERY, 0, 0, 0, 0, 0, 32'd3), 1, answer(0, 0, ST_BAD_SIZE));
    add_reg_row(CFG_FIXED, 32'hFFFF_FFFF);
    add_row(make_item(FUNC_QUERY, 0, 0, 0, 0, 0, 32'd1));
    add_row(make_item(FUNC_QUERY, 0, 0, 0, 0, 0, 32'd2), 1,
            answer(64'd100, 32'hFFFF_FFFF, ST_OK));
    // zero samples per chunk, then chunk number zero
    add_row(make_item(FUNC_RUN, 0, 32'd1, 32'd0, 0, 0, 0));
    add_row(make_item(FUNC_QUERY, 0, 0, 0, 0, 0, 32'd0), 1, answer(0, 0, ST_BAD_CHUNK));
    add_row(make_item(FUNC_RUN, 0, 32'd0, 32'd1, 0, 0, 0));
    add_row(make_item(FUNC_QUERY, 0, 0, 0, 0, 0, 32'd0), 1, answer(0, 0, ST_BAD_CHUNK));

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].is_reg) write_reg(script[i].reg_idx, script[i].reg_data);
      else begin
        maybe_gap();
        send_item(script[i].item, script[i].typed, script[i].want);
      end
    end

    for (int ph = 0; sent < ITEM_GOAL; ph++) random_phase(ph, 120);

    req.valid <= 1'b0;
    while (awaited_answers.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0 && awaited_answers.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sample_table_offset_lookup.f =====
rtl/stol_pkg.sv
rtl/stol_if.sv
rtl/stol_ram.sv
rtl/stol_queue.sv
rtl/stol_front.sv
rtl/stol_back.sv
rtl/sample_table_offset_lookup.sv
tb/tb_top.sv
